FILE: hw/rtl/lr_pkg.sv
// Shared definitions for the line rasterizer: field widths, command codes,
// configuration register indexes and register reset values.
// No dependencies.
`default_nettype none

package lr_pkg;

	// Fixed widths of the ports.
	localparam int CFG_W      = 11;
	localparam int CFG_IDX_W  = 1;
	localparam int COORD_IN_W = 12;
	localparam int PIX_W      = 10;
	localparam int ADDR_W     = 20;
	localparam int COLOR_W    = 24;

	// Register reset values for the image dimensions.
	localparam int WIDTH_RESET  = 640;
	localparam int HEIGHT_RESET = 480;

	// Input beat commands.
	typedef enum logic [0:0] {
		CMD_START = 1'b0,
		CMD_TICK  = 1'b1
	} cmd_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} cfg_reg_t;

endpackage

`default_nettype wire

FILE: hw/rtl/lr_setup.sv
// Line setup: clamps both endpoints into the image, picks the major axis,
// orders the endpoints along it and derives the deltas and step direction.
// Depends on lr_pkg.
`default_nettype none

module lr_setup #(
	parameter int CW = 10,
	parameter int DW = 11
) (
	input  wire logic [lr_pkg::COORD_IN_W-1:0] start_x,
	input  wire logic [lr_pkg::COORD_IN_W-1:0] start_y,
	input  wire logic [lr_pkg::COORD_IN_W-1:0] end_x,
	input  wire logic [lr_pkg::COORD_IN_W-1:0] end_y,
	input  wire logic [DW-1:0]                 width,
	input  wire logic [DW-1:0]                 height,
	output logic                               major_is_x,
	output logic [CW-1:0]                      major_start,
	output logic [CW-1:0]                      major_end,
	output logic [CW-1:0]                      minor_start,
	output logic                               minor_negative,
	output logic [CW-1:0]                      major_delta,
	output logic [CW-1:0]                      minor_delta,
	output logic                               nonzero
);

	localparam int CLW = (DW > lr_pkg::COORD_IN_W) ? DW : lr_pkg::COORD_IN_W;

	// Clamp one coordinate to 0..dim-1; dim is never zero here.
	function automatic logic [CW-1:0] clamp(input logic [lr_pkg::COORD_IN_W-1:0] v,
			input logic [DW-1:0] dim);
		logic [DW-1:0]  top;
		logic [CLW-1:0] ve;
		logic [CLW-1:0] te;
		top = dim - DW'(1);
		ve  = CLW'(v);
		te  = CLW'(top);
		return (ve > te) ? te[CW-1:0] : ve[CW-1:0];
	endfunction

	function automatic logic [CW-1:0] abs_diff(input logic [CW-1:0] a, input logic [CW-1:0] b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

	logic [CW-1:0] x1, y1, x2, y2;
	logic [CW-1:0] adx, ady;
	logic [CW-1:0] maj1, maj2, min1, min2;
	logic          swap;

	// Clamp and measure.
	always_comb begin
		x1  = clamp(start_x, width);
		y1  = clamp(start_y, height);
		x2  = clamp(end_x, width);
		y2  = clamp(end_y, height);
		adx = abs_diff(x1, x2);
		ady = abs_diff(y1, y2);
		major_is_x = (ady < adx);
	end

	// Pick the axes, then order the endpoints so the major coordinate rises.
	always_comb begin
		maj1 = major_is_x ? x1 : y1;
		maj2 = major_is_x ? x2 : y2;
		min1 = major_is_x ? y1 : x1;
		min2 = major_is_x ? y2 : x2;
		swap = (maj1 > maj2);
		major_start    = swap ? maj2 : maj1;
		major_end      = swap ? maj1 : maj2;
		minor_start    = swap ? min2 : min1;
		minor_negative = swap ? (min1 < min2) : (min2 < min1);
		major_delta    = abs_diff(maj1, maj2);
		minor_delta    = abs_diff(min1, min2);
		nonzero        = (maj1 != maj2);
	end

endmodule

`default_nettype wire

FILE: hw/rtl/line_rasterizer.sv
// Bresenham line rasterizer: a start beat sets up a line, each tick beat
// on an active line emits one pixel write via the input and output registers;
// one beat is accepted every cycle unless in_stall holds it off, and the output
// register lets the next beat enter while a pixel waits to be taken.
// Reset clears the line and output state and loads 640 by 480 dimensions.
// Depends on lr_pkg and lr_setup.
`default_nettype none

module line_rasterizer #(
	parameter int MAX_DIMENSION = 1024,
	parameter int COLOR_BITS    = 24
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// Configuration write port.
	input  wire logic                              cfg_we,
	input  wire logic [lr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [lr_pkg::CFG_W-1:0]          cfg_wdata,
	// Command channel.
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic                              command,
	input  wire logic [lr_pkg::COORD_IN_W-1:0]     start_x,
	input  wire logic [lr_pkg::COORD_IN_W-1:0]     start_y,
	input  wire logic [lr_pkg::COORD_IN_W-1:0]     end_x,
	input  wire logic [lr_pkg::COORD_IN_W-1:0]     end_y,
	input  wire logic [lr_pkg::COLOR_W-1:0]        line_color,
	// Pixel channel.
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [lr_pkg::PIX_W-1:0]               pixel_x,
	output logic [lr_pkg::PIX_W-1:0]               pixel_y,
	output logic [lr_pkg::ADDR_W-1:0]              pixel_address,
	output logic [lr_pkg::COLOR_W-1:0]             pixel_color,
	output logic                                   last_pixel
);

	localparam int CW    = $clog2(MAX_DIMENSION);
	localparam int DW    = CW + 1;
	localparam int EW    = CW + 3;
	localparam int HW    = (COLOR_BITS < lr_pkg::COLOR_W) ? COLOR_BITS : lr_pkg::COLOR_W;
	localparam int EXT_W = ((DW > lr_pkg::CFG_W) ? DW : lr_pkg::CFG_W) + 1;
	localparam int PW    = CW + DW + 1;
	localparam logic [DW-1:0] MAX_D = DW'(MAX_DIMENSION);
	localparam logic [DW-1:0] RST_WIDTH =
		DW'((lr_pkg::WIDTH_RESET > MAX_DIMENSION) ? MAX_DIMENSION : lr_pkg::WIDTH_RESET);
	localparam logic [DW-1:0] RST_HEIGHT =
		DW'((lr_pkg::HEIGHT_RESET > MAX_DIMENSION) ? MAX_DIMENSION : lr_pkg::HEIGHT_RESET);

	// A dimension of zero acts as one, any value above the maximum as the maximum.
	function automatic logic [DW-1:0] eff_dim(input logic [lr_pkg::CFG_W-1:0] v);
		logic [EXT_W-1:0] ve;
		logic [EXT_W-1:0] me;
		ve = EXT_W'(v);
		me = EXT_W'(MAX_DIMENSION);
		if (v == '0) return DW'(1);
		else if (ve > me) return MAX_D;
		else return ve[DW-1:0];
	endfunction

	// Effective dimensions, stored already limited.
	logic [DW-1:0] width_q, height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RST_WIDTH;
			height_q <= RST_HEIGHT;
		end else if (cfg_we) begin
			case (lr_pkg::cfg_reg_t'(cfg_index))
				lr_pkg::REG_IMAGE_WIDTH:  width_q  <= eff_dim(cfg_wdata);
				lr_pkg::REG_IMAGE_HEIGHT: height_q <= eff_dim(cfg_wdata);
				default: ;
			endcase
		end
	end

	// Input register stage.
	logic                          valid_s1;
	lr_pkg::cmd_t                  cmd_s1;
	logic [lr_pkg::COORD_IN_W-1:0] sx_s1, sy_s1, ex_s1, ey_s1;
	logic [lr_pkg::COLOR_W-1:0]    color_s1;

	// Line state.
	logic          active_q;
	logic          major_is_x_q;
	logic [CW-1:0] major_pos_q, major_end_q, minor_pos_q;
	logic          minor_neg_q;
	logic [CW-1:0] major_delta_q, minor_delta_q;
	logic signed [EW-1:0] error_q;
	logic [HW-1:0] color_q;

	// Output register.
	logic                       out_valid_q;
	logic [lr_pkg::PIX_W-1:0]   pixel_x_q, pixel_y_q;
	logic [lr_pkg::ADDR_W-1:0]  pixel_address_q;
	logic [lr_pkg::COLOR_W-1:0] pixel_color_q;
	logic                       last_pixel_q;

	// Flow control: the staged beat moves on unless it makes a pixel that
	// has nowhere to go.
	logic yields, out_free, advance, in_accept;

	always_comb begin
		yields    = (cmd_s1 == lr_pkg::CMD_TICK) && active_q;
		out_free  = !out_valid_q || !out_stall;
		advance   = valid_s1 && (!yields || out_free);
		in_stall  = valid_s1 && !advance;
		in_accept = in_valid && !in_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_accept || (valid_s1 && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			cmd_s1   <= lr_pkg::cmd_t'(command);
			sx_s1    <= start_x;
			sy_s1    <= start_y;
			ex_s1    <= end_x;
			ey_s1    <= end_y;
			color_s1 <= line_color;
		end
	end

	// Setup of a new line from the staged endpoints.
	logic          su_major_is_x, su_minor_neg, su_nonzero;
	logic [CW-1:0] su_major_start, su_major_end, su_minor_start;
	logic [CW-1:0] su_major_delta, su_minor_delta;

	lr_setup #(
		.CW(CW),
		.DW(DW)
	) u_setup (
		.start_x       (sx_s1),
		.start_y       (sy_s1),
		.end_x         (ex_s1),
		.end_y         (ey_s1),
		.width         (width_q),
		.height        (height_q),
		.major_is_x    (su_major_is_x),
		.major_start   (su_major_start),
		.major_end     (su_major_end),
		.minor_start   (su_minor_start),
		.minor_negative(su_minor_neg),
		.major_delta   (su_major_delta),
		.minor_delta   (su_minor_delta),
		.nonzero       (su_nonzero)
	);

	// One Bresenham step and the pixel it writes.
	logic                 step;
	logic signed [EW-1:0] major_delta_e, error_stepped, error_next;
	logic [CW-1:0]        minor_next, major_next, px, py;
	logic [PW-1:0]        addr_full;
	logic                 last;
	logic [CW+lr_pkg::PIX_W-1:0]        px_ext, py_ext;
	logic [PW+lr_pkg::ADDR_W-1:0]       addr_ext;
	logic [HW+lr_pkg::COLOR_W-1:0]      color_ext;

	always_comb begin
		major_delta_e = $signed({3'b000, major_delta_q});
		step          = (error_q > major_delta_e);
		if (!step) minor_next = minor_pos_q;
		else if (minor_neg_q) minor_next = minor_pos_q - CW'(1);
		else minor_next = minor_pos_q + CW'(1);
		error_stepped = step ? (error_q - $signed({2'b00, major_delta_q, 1'b0})) : error_q;
		error_next    = error_stepped + $signed({2'b00, minor_delta_q, 1'b0});
		px            = major_is_x_q ? major_pos_q : minor_next;
		py            = major_is_x_q ? minor_next : major_pos_q;
		addr_full     = (PW'(py) * PW'(width_q)) + PW'(px);
		major_next    = major_pos_q + CW'(1);
		last          = (major_next >= major_end_q);
		px_ext        = {{lr_pkg::PIX_W{1'b0}}, px};
		py_ext        = {{lr_pkg::PIX_W{1'b0}}, py};
		addr_ext      = {{lr_pkg::ADDR_W{1'b0}}, addr_full};
		color_ext     = {{lr_pkg::COLOR_W{1'b0}}, color_q};
	end

	// Line state update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (advance) begin
			if (cmd_s1 == lr_pkg::CMD_START) begin
				active_q <= su_nonzero;
			end else if (active_q && last) begin
				active_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (cmd_s1 == lr_pkg::CMD_START) begin
				major_is_x_q  <= su_major_is_x;
				major_pos_q   <= su_major_start;
				major_end_q   <= su_major_end;
				minor_pos_q   <= su_minor_start;
				minor_neg_q   <= su_minor_neg;
				major_delta_q <= su_major_delta;
				minor_delta_q <= su_minor_delta;
				error_q       <= '0;
				color_q       <= color_s1[HW-1:0];
			end else if (active_q) begin
				major_pos_q <= major_next;
				minor_pos_q <= minor_next;
				error_q     <= error_next;
			end
		end
	end

	// Output register: holds a pixel until the consumer takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && yields) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && yields) begin
			pixel_x_q       <= px_ext[lr_pkg::PIX_W-1:0];
			pixel_y_q       <= py_ext[lr_pkg::PIX_W-1:0];
			pixel_address_q <= addr_ext[lr_pkg::ADDR_W-1:0];
			pixel_color_q   <= color_ext[lr_pkg::COLOR_W-1:0];
			last_pixel_q    <= last;
		end
	end

	assign out_valid     = out_valid_q;
	assign pixel_x       = pixel_x_q;
	assign pixel_y       = pixel_y_q;
	assign pixel_address = pixel_address_q;
	assign pixel_color   = pixel_color_q;
	assign last_pixel    = last_pixel_q;

endmodule

`default_nettype wire

FILE: hw/rtl/lr_checker.sv
// Port-level checks for the line rasterizer, bound to the top level.
// Depends on lr_pkg and line_rasterizer.
`default_nettype none

module lr_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          in_valid,
	input wire logic                          in_stall,
	input wire logic                          out_valid,
	input wire logic                          out_stall,
	input wire logic [lr_pkg::PIX_W-1:0]      pixel_x,
	input wire logic [lr_pkg::PIX_W-1:0]      pixel_y,
	input wire logic [lr_pkg::ADDR_W-1:0]     pixel_address,
	input wire logic [lr_pkg::COLOR_W-1:0]    pixel_color,
	input wire logic                          last_pixel
);

	// While reset is held nothing is offered and nothing is refused.
	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> (!out_valid && !in_stall))
		else $error("outputs active during reset");

	// A stalled pixel beat stays offered and unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(pixel_x) && $stable(pixel_y)
			&& $stable(pixel_address) && $stable(pixel_color) && $stable(last_pixel)))
		else $error("stalled pixel beat changed");

	// With the output register empty the input side is never held off.
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled while output register empty");

	// A pixel appearing on an empty output comes from an accepted command beat, held in the input register on the way.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("pixel beat without a matching command beat");

endmodule

bind line_rasterizer lr_checker u_lr_checker (.*);

`default_nettype wire
